[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file slmd_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define SLMD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off while reset is high.
`define SLMD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Condition that must hold in the cycle after reset is seen.
`define SLMD_ASSERT_RST(lbl, clk, rst, cons) \
  lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("reset assertion failed");

`endif

[hw/rtl/slmd_pkg.sv]
// Shared constants, codes and helpers of the local maximum detector.
`timescale 1ns / 1ps
package slmd_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int SIZE_W     = 13;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

  // result slots of one request
  localparam int SLOT_ABOVE = 0;
  localparam int SLOT_LEFT  = 1;
  localparam int SLOT_FINAL = 2;
  localparam int SLOT_N     = 3;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef logic [CFG_DATA_W-1:0] cfg_size_t;
  typedef logic [SLOT_N-1:0]     slot_mask_t;

  // zero acts as one, oversize clips to the maximum
  function automatic logic [SIZE_W-1:0] eff_size(input cfg_size_t val,
                                                 input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] ext;
    begin
      ext = SIZE_W'(val);
      if (val == '0) begin
        eff_size = SIZE_W'(1);
      end else if (ext > maxv) begin
        eff_size = maxv;
      end else begin
        eff_size = ext;
      end
    end
  endfunction

endpackage

[hw/rtl/slmd_if.sv]
// Channel interfaces: configuration writes, pixel requests, result requests.
`timescale 1ns / 1ps
interface slmd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [slmd_pkg::CFG_IDX_W-1:0]  index;
  logic [slmd_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface slmd_pix_if #(parameter int DW = 16);
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] pixel_value;
  modport source (output valid, pixel_value, input ready);
  modport sink   (input valid, pixel_value, output ready);
endinterface

interface slmd_res_if #(parameter int RW = 7, parameter int CW = 7, parameter int DW = 16);
  logic                 valid;
  logic                 ready;
  logic [RW-1:0]        out_row;
  logic [CW-1:0]        out_col;
  logic signed [DW-1:0] out_value;
  logic                 is_peak;
  logic                 frame_last;
  logic                 any_peak;
  modport source (output valid, out_row, out_col, out_value, is_peak, frame_last, any_peak,
                  input ready);
  modport sink   (input valid, out_row, out_col, out_value, is_peak, frame_last, any_peak,
                  output ready);
endinterface

[hw/rtl/strict_local_max_detect.sv]
// Top level of the streaming four-neighbor strict local maximum detector.
//
//   channel  dir  payload                                             request when
//   cfg      in   index, data                                         valid & ready
//   pix      in   pixel_value                                         valid & ready
//   res      out  out_row out_col out_value is_peak frame_last any_peak valid & ready
//
// One pixel per cycle while pix ready is high; stage B and a queue feed the back end.
// Last-row pixels give up to three results, sent one per cycle by the back end when
// res is free; the two-entry queue then fills and pixel ready drops until it drains.
// Reset sets a 1x1 frame and clears position and queue; line buffers are not cleared.
// cfg is always ready; users write it only while the block is idle; not enforced.
`timescale 1ns / 1ps
module strict_local_max_detect #(
  parameter int MAX_ROWS   = 128,
  parameter int MAX_COLS   = 128,
  parameter int DATA_WIDTH = 16
) (
  input logic             clk,
  input logic             rst,
  slmd_cfg_if.sink        cfg,
  slmd_pix_if.sink        pix,
  slmd_res_if.source      res
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = $clog2(MAX_COLS);
  localparam int DW = DATA_WIDTH;

  typedef struct packed {
    logic [RW-1:0]        row;
    logic [CW-1:0]        col;
    logic signed [DW-1:0] v_above;
    logic signed [DW-1:0] v_left;
    logic signed [DW-1:0] v_final;
    slmd_pkg::slot_mask_t has;
    slmd_pkg::slot_mask_t peak;
    logic                 any;
  } job_t;

  slmd_pkg::cfg_size_t row_count, col_count;

  logic f_valid, f_ready, b_valid, b_ready;
  job_t f_job, b_job;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= slmd_pkg::CFG_DATA_W'(1);
      col_count <= slmd_pkg::CFG_DATA_W'(1);
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        slmd_pkg::REG_ROW_COUNT: row_count <= cfg.data;
        slmd_pkg::REG_COL_COUNT: col_count <= cfg.data;
      endcase
    end
  end

  slmd_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .DW       (DW),
    .job_t    (job_t)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .row_count (row_count),
    .col_count (col_count),
    .in_valid  (pix.valid),
    .in_ready  (pix.ready),
    .in_pixel  (pix.pixel_value),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  slmd_queue #(
    .job_t (job_t)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_job),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_job)
  );

  slmd_back #(
    .RW    (RW),
    .CW    (CW),
    .DW    (DW),
    .job_t (job_t)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (b_valid),
    .job_ready  (b_ready),
    .job        (b_job),
    .out_valid  (res.valid),
    .out_ready  (res.ready),
    .out_row    (res.out_row),
    .out_col    (res.out_col),
    .out_value  (res.out_value),
    .is_peak    (res.is_peak),
    .frame_last (res.frame_last),
    .any_peak   (res.any_peak)
  );

endmodule

[hw/rtl/slmd_front.sv]
// Front end: raster position, line buffers, window and peak classification.
`timescale 1ns / 1ps
module slmd_front #(
  parameter int MAX_ROWS = 128,
  parameter int MAX_COLS = 128,
  parameter int DW       = 16,
  parameter type job_t   = logic
) (
  input  logic                       clk,
  input  logic                       rst,
  input  slmd_pkg::cfg_size_t        row_count,
  input  slmd_pkg::cfg_size_t        col_count,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [DW-1:0]       in_pixel,
  output logic                       job_valid,
  input  logic                       job_ready,
  output job_t                       job
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = $clog2(MAX_COLS);
  localparam int SW = slmd_pkg::SIZE_W;
  localparam logic [SW-1:0] MAXR = SW'(MAX_ROWS);
  localparam logic [SW-1:0] MAXC = SW'(MAX_COLS);

  logic signed [DW-1:0] mem_u [MAX_COLS];
  logic signed [DW-1:0] mem_m [MAX_COLS];
  logic signed [DW-1:0] u_rd0, u_rd1, m_rd0, m_rd1;

  logic [RW-1:0] r_pos, r_cur, r_next;
  logic [CW-1:0] c_pos, c_cur, c_next, c_plus;
  logic          swap, swp_cur, swap_next;
  logic [SW-1:0] rows_eff, cols_eff;
  logic          restart, last_row, last_col, final_cur, acc;

  logic signed [DW-1:0] w0, w1;

  // stage B
  logic                 b_valid, b_go;
  logic signed [DW-1:0] b_px, b_w0, b_w1, prev_v;
  logic [RW-1:0]        b_r;
  logic [CW-1:0]        b_c;
  logic                 b_swp, b_has_above, b_up_ok, b_left_ok, b_left2;
  logic                 b_last_row, b_last_col, b_final, b_fresh;
  logic                 peak_seen, peak_seen_next, peak_base, found, any;
  logic signed [DW-1:0] v_new0, v_new1, v_old0;
  slmd_pkg::slot_mask_t has, peak;

  assign rows_eff  = slmd_pkg::eff_size(row_count, MAXR);
  assign cols_eff  = slmd_pkg::eff_size(col_count, MAXC);
  assign restart   = (SW'(r_pos) >= rows_eff) || (SW'(c_pos) >= cols_eff);
  assign r_cur     = restart ? '0 : r_pos;
  assign c_cur     = restart ? '0 : c_pos;
  assign swp_cur   = restart ? 1'b0 : swap;
  assign c_plus    = c_cur + CW'(1);
  assign last_row  = (SW'(r_cur) == rows_eff - SW'(1));
  assign last_col  = (SW'(c_cur) == cols_eff - SW'(1));
  assign final_cur = last_row && last_col;
  assign acc       = in_valid && in_ready;

  always_comb begin
    r_next    = r_cur;
    c_next    = c_cur + CW'(1);
    swap_next = swp_cur;
    if (final_cur) begin
      r_next    = '0;
      c_next    = '0;
      swap_next = 1'b0;
    end else if (last_col) begin
      r_next    = r_cur + RW'(1);
      c_next    = '0;
      swap_next = ~swp_cur;
    end
  end

  // upper buffer holds the older row when swap is low
  always_ff @(posedge clk) begin
    if (acc) begin
      u_rd0 <= mem_u[c_cur];
      u_rd1 <= mem_u[c_plus];
      if (!final_cur && !swp_cur) begin
        mem_u[c_cur] <= in_pixel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      m_rd0 <= mem_m[c_cur];
      m_rd1 <= mem_m[c_plus];
      if (!final_cur && swp_cur) begin
        mem_m[c_cur] <= in_pixel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      r_pos     <= '0;
      c_pos     <= '0;
      swap      <= 1'b0;
      peak_seen <= 1'b0;
    end else begin
      if (acc) begin
        b_valid <= 1'b1;
        r_pos   <= r_next;
        c_pos   <= c_next;
        swap    <= swap_next;
      end else if (b_go) begin
        b_valid <= 1'b0;
      end
      if (b_go) begin
        peak_seen <= peak_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      b_px        <= in_pixel;
      b_r         <= r_cur;
      b_c         <= c_cur;
      b_w0        <= w0;
      b_w1        <= w1;
      b_swp       <= swp_cur;
      b_has_above <= (r_cur != '0);
      b_up_ok     <= (r_cur > RW'(1));
      b_left_ok   <= (c_cur != '0);
      b_left2     <= (c_cur > CW'(1));
      b_last_row  <= last_row;
      b_last_col  <= last_col;
      b_final     <= final_cur;
      b_fresh     <= (r_cur == '0) && (c_cur == '0);
      w1          <= w0;
      w0          <= in_pixel;
    end
    if (b_go) begin
      prev_v <= v_new0;
    end
  end

  assign v_new0 = b_swp ? u_rd0 : m_rd0;
  assign v_new1 = b_swp ? u_rd1 : m_rd1;
  assign v_old0 = b_swp ? m_rd0 : u_rd0;

  always_comb begin
    has  = '0;
    peak = '0;
    has[slmd_pkg::SLOT_ABOVE]  = b_has_above;
    has[slmd_pkg::SLOT_LEFT]   = b_last_row && b_left_ok;
    has[slmd_pkg::SLOT_FINAL]  = b_final;
    peak[slmd_pkg::SLOT_ABOVE] = (!b_up_ok || (v_new0 > v_old0)) && (v_new0 > b_px)
                                 && (!b_left_ok || (v_new0 > prev_v))
                                 && (b_last_col || (v_new0 > v_new1));
    peak[slmd_pkg::SLOT_LEFT]  = (!b_has_above || (b_w0 > prev_v))
                                 && (!b_left2 || (b_w0 > b_w1)) && (b_w0 > b_px);
    peak[slmd_pkg::SLOT_FINAL] = (!b_has_above || (b_px > v_new0))
                                 && (!b_left_ok || (b_px > b_w0));
  end

  assign found          = |(has & peak);
  assign peak_base      = b_fresh ? 1'b0 : peak_seen;
  assign any            = peak_base | found;
  assign peak_seen_next = b_final ? 1'b0 : any;

  assign job_valid = b_valid && (|has);
  assign b_go      = b_valid && (job_ready || !(|has));
  assign in_ready  = !b_valid || b_go;

  always_comb begin
    job         = '0;
    job.row     = b_r;
    job.col     = b_c;
    job.v_above = v_new0;
    job.v_left  = b_w0;
    job.v_final = b_px;
    job.has     = has;
    job.peak    = peak;
    job.any     = any;
  end

endmodule

[hw/rtl/slmd_queue.sv]
// Two-entry queue between the front end and the result sequencer.
`timescale 1ns / 1ps
module slmd_queue #(
  parameter type job_t = logic
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);

  job_t                          q [slmd_pkg::Q_DEPTH];
  logic [slmd_pkg::Q_PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [slmd_pkg::Q_CNT_W-1:0]  count;
  logic                          do_push, do_pop;

  assign push_ready = (count != slmd_pkg::Q_CNT_W'(slmd_pkg::Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = q[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + slmd_pkg::Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + slmd_pkg::Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + slmd_pkg::Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - slmd_pkg::Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= push_data;
    end
  end

endmodule

[hw/rtl/slmd_back.sv]
// Back end: sends the decisions of each request one per cycle while the output is free.
`timescale 1ns / 1ps
module slmd_back #(
  parameter int RW     = 7,
  parameter int CW     = 7,
  parameter int DW     = 16,
  parameter type job_t = logic
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  job_t                 job,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [RW-1:0]        out_row,
  output logic [CW-1:0]        out_col,
  output logic signed [DW-1:0] out_value,
  output logic                 is_peak,
  output logic                 frame_last,
  output logic                 any_peak
);

  job_t                 cur;
  slmd_pkg::slot_mask_t pend, sel, pend_left;
  logic                 out_free, emit;

  assign out_free = !out_valid || out_ready;
  assign emit     = out_free && (|pend);

  always_comb begin
    sel = '0;
    if (pend[slmd_pkg::SLOT_ABOVE]) begin
      sel[slmd_pkg::SLOT_ABOVE] = 1'b1;
    end else if (pend[slmd_pkg::SLOT_LEFT]) begin
      sel[slmd_pkg::SLOT_LEFT] = 1'b1;
    end else begin
      sel[slmd_pkg::SLOT_FINAL] = pend[slmd_pkg::SLOT_FINAL];
    end
  end

  assign pend_left = emit ? (pend & ~sel) : pend;
  assign job_ready = (pend_left == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (job_ready) begin
        pend <= job_valid ? job.has : '0;
      end else begin
        pend <= pend_left;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      cur <= job;
    end
    if (emit) begin
      if (sel[slmd_pkg::SLOT_ABOVE]) begin
        out_row    <= cur.row - RW'(1);
        out_col    <= cur.col;
        out_value  <= cur.v_above;
        is_peak    <= cur.peak[slmd_pkg::SLOT_ABOVE];
        frame_last <= 1'b0;
        any_peak   <= 1'b0;
      end else if (sel[slmd_pkg::SLOT_LEFT]) begin
        out_row    <= cur.row;
        out_col    <= cur.col - CW'(1);
        out_value  <= cur.v_left;
        is_peak    <= cur.peak[slmd_pkg::SLOT_LEFT];
        frame_last <= 1'b0;
        any_peak   <= 1'b0;
      end else begin
        out_row    <= cur.row;
        out_col    <= cur.col;
        out_value  <= cur.v_final;
        is_peak    <= cur.peak[slmd_pkg::SLOT_FINAL];
        frame_last <= 1'b1;
        any_peak   <= cur.any;
      end
    end
  end

endmodule

[hw/rtl/slmd_checker.sv]
// Port-level checks of the local maximum detector, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module slmd_checker #(
  parameter int DW = 16
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 res_valid,
  input logic                 res_ready,
  input logic signed [DW-1:0] out_value,
  input logic                 is_peak,
  input logic                 frame_last,
  input logic                 any_peak,
  input logic                 pos_zero
);

  `SLMD_ASSERT_IMP(a_any_only_last, clk, rst, res_valid && !frame_last, !any_peak)
  `SLMD_ASSERT_IMP(a_peak_sets_any, clk, rst, res_valid && frame_last && is_peak, any_peak)
  `SLMD_ASSERT_IMP(a_single_peak, clk, rst, res_valid && frame_last && pos_zero, is_peak)
  `SLMD_ASSERT_NXT(a_res_hold, clk, rst, res_valid && !res_ready,
    res_valid && $stable(out_value) && $stable(is_peak) && $stable(frame_last))
  `SLMD_ASSERT_RST(a_rst_idle, clk, rst, !res_valid)

endmodule

bind strict_local_max_detect slmd_checker #(.DW(DATA_WIDTH)) u_slmd_chk (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .out_value  (res.out_value),
  .is_peak    (res.is_peak),
  .frame_last (res.frame_last),
  .any_peak   (res.any_peak),
  .pos_zero   ((res.out_row == '0) && (res.out_col == '0))
);
